FILE: design/entity_percent_decoder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the entity and percent decoder
// Concurrent checks on clk_i / rst_ni; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ENTITY_PERCENT_DECODER_DEFINES_SVH
`define ENTITY_PERCENT_DECODER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define EPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define EPD_ASSERT_IMP(lbl, ante, cons, msg)
`define EPD_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: design/epd_pkg.sv
// ----------------------------------------------------------------------------
// epd_pkg
// Types, character codes and helper functions for the entity and percent
// decoder.
// ----------------------------------------------------------------------------
package epd_pkg;

  localparam int OutCnt    = 8;  // most result bytes per request
  localparam int FeedCnt   = 6;  // most bytes handed from entity stage to escape stage
  localparam int PrefixMax = 5;  // longest held entity prefix

  localparam logic [7:0] ChAmp   = "&";
  localparam logic [7:0] ChQuote = "\"";
  localparam logic [7:0] ChApos  = "'";
  localparam logic [7:0] ChHash  = "#";
  localparam logic [7:0] ChPct   = "%";
  localparam logic [7:0] ChSemi  = ";";
  localparam logic [7:0] ChLowA  = "a";
  localparam logic [7:0] ChLowM  = "m";
  localparam logic [7:0] ChLowP  = "p";
  localparam logic [7:0] ChLowQ  = "q";
  localparam logic [7:0] ChLowU  = "u";
  localparam logic [7:0] ChLowO  = "o";
  localparam logic [7:0] ChLowT  = "t";
  localparam logic [7:0] ChDig3  = "3";
  localparam logic [7:0] ChDig4  = "4";
  localparam logic [7:0] ChDig9  = "9";

  // entity prefix held by the first stage
  typedef enum logic [3:0] {
    EntNone = 4'd0,   // nothing held
    EntAmp  = 4'd1,   // &
    EntA    = 4'd2,   // &a
    EntAm   = 4'd3,   // &am
    EntAmpP = 4'd4,   // &amp
    EntQ    = 4'd5,   // &q
    EntQu   = 4'd6,   // &qu
    EntQuo  = 4'd7,   // &quo
    EntQuot = 4'd8,   // &quot
    EntHash = 4'd9,   // &#
    EntH3   = 4'd10,  // &#3
    EntH39  = 4'd11,  // &#39
    EntH34  = 4'd12   // &#34
  } ent_state_e;

  // percent escape progress in the second stage
  typedef enum logic [1:0] {
    EscIdle  = 2'd0,
    EscPct   = 2'd1,
    EscDigit = 2'd2
  } esc_phase_e;

  // outcome of one byte through the escape stage
  typedef struct packed {
    esc_phase_e      phase;
    logic [7:0]      held;
    logic [1:0]      cnt;
    logic [2:0][7:0] ch;
  } esc_step_t;

  function automatic logic [2:0] prefix_len(ent_state_e s);
    logic [2:0] len;
    case (s)
      EntAmp:                               len = 3'd1;
      EntA, EntQ, EntHash:                  len = 3'd2;
      EntAm, EntQu, EntH3:                  len = 3'd3;
      EntAmpP, EntQuo, EntH39, EntH34:      len = 3'd4;
      EntQuot:                              len = 3'd5;
      default:                              len = 3'd0;
    endcase
    return len;
  endfunction

  // held text, left aligned in five byte slots
  function automatic logic [39:0] prefix_text(ent_state_e s);
    logic [39:0] txt;
    case (s)
      EntAmp:  txt = {"&", 32'h0};
      EntA:    txt = {"&a", 24'h0};
      EntAm:   txt = {"&am", 16'h0};
      EntAmpP: txt = {"&amp", 8'h0};
      EntQ:    txt = {"&q", 24'h0};
      EntQu:   txt = {"&qu", 16'h0};
      EntQuo:  txt = {"&quo", 8'h0};
      EntQuot: txt = "&quot";
      EntHash: txt = {"&#", 24'h0};
      EntH3:   txt = {"&#3", 16'h0};
      EntH39:  txt = {"&#39", 8'h0};
      EntH34:  txt = {"&#34", 8'h0};
      default: txt = '0;
    endcase
    return txt;
  endfunction

  function automatic logic [7:0] prefix_char(ent_state_e s, logic [2:0] idx);
    logic [39:0] txt;
    logic [7:0]  ch;
    txt = prefix_text(s);
    case (idx)
      3'd0:    ch = txt[39:32];
      3'd1:    ch = txt[31:24];
      3'd2:    ch = txt[23:16];
      3'd3:    ch = txt[15:8];
      3'd4:    ch = txt[7:0];
      default: ch = '0;
    endcase
    return ch;
  endfunction

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] v;
    if (c >= "0" && c <= "9") begin
      v = 5'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      v = 5'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      v = 5'(c - "A" + 8'd10);
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

  function automatic esc_step_t esc_step(esc_phase_e phase, logic [7:0] held, logic [7:0] c);
    esc_step_t  r;
    logic [4:0] v;
    logic [4:0] hv;
    v       = hex_val(c);
    hv      = hex_val(held);
    r.phase = EscIdle;
    r.held  = held;
    r.cnt   = 2'd0;
    r.ch    = '0;
    case (phase)
      EscPct: begin
        if (!v[4]) begin
          r.held  = c;
          r.phase = EscDigit;
        end else begin
          r.ch[0] = ChPct;
          r.cnt   = 2'd1;
          if (c == ChPct) begin
            r.phase = EscPct;
          end else begin
            r.ch[1] = c;
            r.cnt   = 2'd2;
          end
        end
      end
      EscDigit: begin
        r.held = '0;
        if (!v[4]) begin
          r.ch[0] = {hv[3:0], v[3:0]};
          r.cnt   = 2'd1;
        end else begin
          r.ch[0] = ChPct;
          r.ch[1] = held;
          r.cnt   = 2'd2;
          if (c == ChPct) begin
            r.phase = EscPct;
          end else begin
            r.ch[2] = c;
            r.cnt   = 2'd3;
          end
        end
      end
      default: begin
        if (c == ChPct) begin
          r.phase = EscPct;
        end else begin
          r.ch[0] = c;
          r.cnt   = 2'd1;
        end
      end
    endcase
    return r;
  endfunction

endpackage

FILE: design/entity_percent_decoder.sv
// Entity and percent decoder: one text byte per request in, decoded bytes out.
// A byte is taken into an input register, decoded combinationally (entity
// stage, then percent stage) and its results, up to eight bytes, are loaded
// into an output buffer that hands out one byte per cycle while the output is
// not stalled. An input byte that yields zero or one result lets the next byte
// in on the following cycle when the output is not stalled, so plain text then
// runs at one byte per cycle; a byte that yields more results (a failed entity
// or escape, or the flush on the last byte) stalls the input while the output
// buffer drains, and for longer while the output is stalled.
// ----------------------------------------------------------------------------
// entity_percent_decoder
// Streaming HTML entity and URL percent decoder, single pass per byte.
// ----------------------------------------------------------------------------
`include "entity_percent_decoder_defines.svh"

module entity_percent_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  import epd_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_last_q;

  // decoder state
  ent_state_e ent_q, ent_d, ent_nxt;
  esc_phase_e esc_q, esc_d;
  logic [7:0] held_q, held_d;

  // entity stage
  logic       done_ok;
  logic [7:0] done_ch;
  logic [7:0] feed [FeedCnt];
  logic [2:0] n_feed;
  logic [3:0] idx;

  // escape stage
  esc_step_t  step;
  logic [7:0] res_d [OutCnt];
  logic [3:0] n_res;

  // output buffer
  logic [7:0] res_q [OutCnt];
  logic [3:0] left_q;
  logic [2:0] rd_q;
  logic       blast_q;

  logic in_fire, out_fire, load;

  assign out_valid_o = (left_q != 4'd0);
  assign out_char_o  = res_q[rd_q];
  assign out_last_o  = blast_q && (left_q == 4'd1);
  assign out_fire    = out_valid_o && !out_stall_i;

  assign load       = in_valid_q && ((left_q == 4'd0) || ((left_q == 4'd1) && out_fire));
  assign in_stall_o = in_valid_q && !load;
  assign in_fire    = in_valid_i && !in_stall_o;

  // entity continuation
  always_comb begin : ent_next
    ent_nxt = EntNone;
    done_ok = 1'b0;
    done_ch = '0;
    case (ent_q)
      EntAmp: begin
        if (in_char_q == ChLowA) begin
          ent_nxt = EntA;
        end else if (in_char_q == ChLowQ) begin
          ent_nxt = EntQ;
        end else if (in_char_q == ChHash) begin
          ent_nxt = EntHash;
        end
      end
      EntA:    if (in_char_q == ChLowM) ent_nxt = EntAm;
      EntAm:   if (in_char_q == ChLowP) ent_nxt = EntAmpP;
      EntAmpP: begin
        done_ok = (in_char_q == ChSemi);
        done_ch = ChAmp;
      end
      EntQ:    if (in_char_q == ChLowU) ent_nxt = EntQu;
      EntQu:   if (in_char_q == ChLowO) ent_nxt = EntQuo;
      EntQuo:  if (in_char_q == ChLowT) ent_nxt = EntQuot;
      EntQuot: begin
        done_ok = (in_char_q == ChSemi);
        done_ch = ChQuote;
      end
      EntHash: if (in_char_q == ChDig3) ent_nxt = EntH3;
      EntH3: begin
        if (in_char_q == ChDig9) begin
          ent_nxt = EntH39;
        end else if (in_char_q == ChDig4) begin
          ent_nxt = EntH34;
        end
      end
      EntH39: begin
        done_ok = (in_char_q == ChSemi);
        done_ch = ChApos;
      end
      EntH34: begin
        done_ok = (in_char_q == ChSemi);
        done_ch = ChQuote;
      end
      default: ;
    endcase
  end

  // bytes handed on to the escape stage
  always_comb begin : ent_feed
    ent_d  = EntNone;
    feed   = '{default: '0};
    n_feed = '0;
    idx    = '0;
    if (ent_q == EntNone) begin
      if (in_char_q == ChAmp) begin
        ent_d = EntAmp;
      end else begin
        feed[0] = in_char_q;
        n_feed  = 3'd1;
      end
    end else if (ent_nxt != EntNone) begin
      ent_d = ent_nxt;
    end else if (done_ok) begin
      feed[0] = done_ch;
      n_feed  = 3'd1;
    end else begin
      // broken prefix goes out literally, breaking byte is looked at afresh
      for (int i = 0; i < PrefixMax; i++) begin
        if (3'(i) < prefix_len(ent_q)) feed[i] = prefix_char(ent_q, 3'(i));
      end
      n_feed = prefix_len(ent_q);
      if (in_char_q == ChAmp) begin
        ent_d = EntAmp;
      end else begin
        feed[n_feed] = in_char_q;
        n_feed       = n_feed + 3'd1;
      end
    end
    if (in_last_q) begin
      for (int i = 0; i < PrefixMax; i++) begin
        idx = {1'b0, n_feed} + 4'(i);
        if (3'(i) < prefix_len(ent_d) && idx < 4'(FeedCnt)) begin
          feed[idx[2:0]] = prefix_char(ent_d, 3'(i));
        end
      end
      n_feed = n_feed + prefix_len(ent_d);
      ent_d  = EntNone;
    end
  end

  // escape stage run over the handed-on bytes, results packed in order
  always_comb begin : esc_chain
    esc_d  = esc_q;
    held_d = held_q;
    n_res  = '0;
    res_d  = '{default: '0};
    step   = '0;
    for (int j = 0; j < FeedCnt; j++) begin
      if (3'(j) < n_feed) begin
        step   = esc_step(esc_d, held_d, feed[j]);
        esc_d  = step.phase;
        held_d = step.held;
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < step.cnt && n_res < 4'(OutCnt)) begin
            res_d[n_res[2:0]] = step.ch[k];
            n_res             = n_res + 4'd1;
          end
        end
      end
    end
    if (in_last_q) begin
      if (esc_d != EscIdle && n_res < 4'(OutCnt)) begin
        res_d[n_res[2:0]] = ChPct;
        n_res             = n_res + 4'd1;
      end
      if (esc_d == EscDigit && n_res < 4'(OutCnt)) begin
        res_d[n_res[2:0]] = held_d;
        n_res             = n_res + 4'd1;
      end
      esc_d  = EscIdle;
      held_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_char_q <= in_char_i;
      in_last_q <= in_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q  <= EntNone;
      esc_q  <= EscIdle;
      held_q <= '0;
    end else if (load) begin
      ent_q  <= ent_d;
      esc_q  <= esc_d;
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      rd_q    <= '0;
      blast_q <= 1'b0;
    end else if (load) begin
      left_q  <= n_res;
      rd_q    <= '0;
      blast_q <= in_last_q;
    end else if (out_fire) begin
      left_q <= left_q - 4'd1;
      rd_q   <= rd_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  `EPD_ASSERT_IMP(a_stall_busy, in_stall_o, left_q != 4'd0, "input stalled with empty output buffer")
  `EPD_ASSERT_NXT(a_last_clears, load && in_last_q, ent_q == EntNone && esc_q == EscIdle, "state held after last byte")
  `EPD_ASSERT_NXT(a_drain_gapless, out_fire && left_q > 4'd1, out_valid_o && left_q == $past(left_q) - 4'd1, "output buffer drain broken")

endmodule

FILE: tb/sv/entity_percent_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// entity_percent_decoder_tb
// Streams text into the decoder with random gaps and output back-pressure.
// A short directed table comes first, then random strings built from entity
// and percent-escape fragments. Each decoded byte is checked in order against
// the table row's expectation or a behavioural copy of both decode stages.
// ----------------------------------------------------------------------------
module entity_percent_decoder_tb;
  import epd_pkg::*;

  localparam int ItemTarget = 320;
  localparam int Limit      = 400000;
  localparam int HoldCycles = 80;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;  // expectation given in the row, not from the decode model
    logic       one;    // typed row yields one byte
    logic [7:0] want;
  } table_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_char_i   = 8'h00;
  logic       in_last_i   = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_char_o;
  logic       out_last_o;

  entity_percent_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_char_i  (in_char_i),
    .in_last_i  (in_last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_char_o (out_char_o),
    .out_last_o (out_last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // decoder state mirrored by the predictor
  ent_state_e ent_q      = EntNone;
  esc_phase_e esc_q      = EscIdle;
  logic [7:0] held_digit = 8'h00;
  logic [7:0] new_bytes[$];

  out_byte_t  decoded_q[$];
  logic [7:0] str_q[$];
  table_row_t dir_rows[$];

  int errors     = 0;
  int cycles     = 0;
  int sent       = 0;
  bit quiet      = 1'b0;
  int hold_req   = 0;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return {1'b0, 4'(c[3:0] + 4'd9)};
    return 5'h10;
  endfunction

  function automatic void esc_plain(logic [7:0] c);
    if (c == ChPct) esc_q = EscPct;
    else new_bytes.push_back(c);
  endfunction

  function automatic void esc_take(logic [7:0] c);
    logic [4:0] v;
    logic [4:0] hv;
    v  = hex_nibble(c);
    hv = hex_nibble(held_digit);
    case (esc_q)
      EscPct: begin
        if (!v[4]) begin
          held_digit = c;
          esc_q      = EscDigit;
        end else begin
          new_bytes.push_back(ChPct);
          esc_q = EscIdle;
          esc_plain(c);
        end
      end
      EscDigit: begin
        esc_q = EscIdle;
        if (!v[4]) begin
          new_bytes.push_back({hv[3:0], v[3:0]});
        end else begin
          new_bytes.push_back(ChPct);
          new_bytes.push_back(held_digit);
        end
        held_digit = 8'h00;
        if (v[4]) esc_plain(c);
      end
      default: begin
        esc_q = EscIdle;
        esc_plain(c);
      end
    endcase
  endfunction

  // done[8] clear: entity complete, done[7:0] is the decoded byte
  function automatic ent_state_e ent_advance(ent_state_e s, logic [7:0] c,
                                             output logic [8:0] done);
    ent_state_e nxt;
    nxt  = EntNone;
    done = 9'h100;
    case (s)
      EntAmp: begin
        if (c == ChLowA) nxt = EntA;
        else if (c == ChLowQ) nxt = EntQ;
        else if (c == ChHash) nxt = EntHash;
      end
      EntA:    if (c == ChLowM) nxt = EntAm;
      EntAm:   if (c == ChLowP) nxt = EntAmpP;
      EntAmpP: if (c == ChSemi) done = {1'b0, ChAmp};
      EntQ:    if (c == ChLowU) nxt = EntQu;
      EntQu:   if (c == ChLowO) nxt = EntQuo;
      EntQuo:  if (c == ChLowT) nxt = EntQuot;
      EntQuot: if (c == ChSemi) done = {1'b0, ChQuote};
      EntHash: if (c == ChDig3) nxt = EntH3;
      EntH3: begin
        if (c == ChDig9) nxt = EntH39;
        else if (c == ChDig4) nxt = EntH34;
      end
      EntH39:  if (c == ChSemi) done = {1'b0, ChApos};
      EntH34:  if (c == ChSemi) done = {1'b0, ChQuote};
      default: nxt = EntNone;
    endcase
    return nxt;
  endfunction

  function automatic string held_text(ent_state_e s);
    case (s)
      EntAmp:  return "&";
      EntA:    return "&a";
      EntAm:   return "&am";
      EntAmpP: return "&amp";
      EntQ:    return "&q";
      EntQu:   return "&qu";
      EntQuo:  return "&quo";
      EntQuot: return "&quot";
      EntHash: return "&#";
      EntH3:   return "&#3";
      EntH39:  return "&#39";
      EntH34:  return "&#34";
      default: return "";
    endcase
  endfunction

  // a broken prefix goes on to the escape stage as literal text
  function automatic void flush_held(ent_state_e s);
    string txt;
    txt = held_text(s);
    for (int i = 0; i < txt.len(); i++) esc_take(txt[i]);
  endfunction

  function automatic void ent_plain(logic [7:0] c);
    if (c == ChAmp) ent_q = EntAmp;
    else esc_take(c);
  endfunction

  function automatic void ent_take(logic [7:0] c);
    ent_state_e s;
    ent_state_e nxt;
    logic [8:0] done;
    s = ent_q;
    if (s == EntNone) begin
      ent_plain(c);
    end else begin
      nxt = ent_advance(s, c, done);
      if (nxt != EntNone) begin
        ent_q = nxt;
      end else begin
        ent_q = EntNone;
        if (!done[8]) begin
          esc_take(done[7:0]);
        end else begin
          flush_held(s);
          ent_plain(c);
        end
      end
    end
  endfunction

  function automatic void decode_byte(logic [7:0] c, logic last);
    ent_state_e s;
    new_bytes.delete();
    ent_take(c);
    if (last) begin
      s     = ent_q;
      ent_q = EntNone;
      flush_held(s);
      if (esc_q == EscPct) begin
        new_bytes.push_back(ChPct);
      end else if (esc_q == EscDigit) begin
        new_bytes.push_back(ChPct);
        new_bytes.push_back(held_digit);
      end
      esc_q      = EscIdle;
      held_digit = 8'h00;
    end
  endfunction

  function automatic table_row_t table_row(logic [7:0] ch, logic last, logic typed,
                                           logic one, logic [7:0] want);
    table_row_t r;
    r = '{ch, last, typed, one, want};
    return r;
  endfunction

  function automatic logic [7:0] hex_char();
    int unsigned v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(v) + "0";
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(v - 10);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    logic [4:0] v;
    do begin
      c = 8'($urandom_range(0, 255));
      v = hex_nibble(c);
    end while (!v[4]);
    return c;
  endfunction

  function automatic string entity_text(int unsigned k);
    case (k)
      0:       return "&amp;";
      1:       return "&quot;";
      2:       return "&#39;";
      default: return "&#34;";
    endcase
  endfunction

  // one string of mostly well-formed fragments; a cut entity or escape at the
  // end exercises the flush on the last byte
  task automatic build_string();
    int unsigned tokens;
    int unsigned kind;
    int unsigned cut;
    string       txt;
    string       odd;
    str_q.delete();
    odd    = "&%;#amqpuot349";
    tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 6);
    repeat (tokens) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: str_q.push_back(8'($urandom_range(0, 255)));
        3, 4: begin
          txt = entity_text($urandom_range(0, 3));
          for (int i = 0; i < txt.len(); i++) str_q.push_back(txt[i]);
        end
        5: begin
          txt = entity_text($urandom_range(0, 3));
          cut = $urandom_range(1, txt.len() - 1);
          for (int i = 0; i < cut; i++) str_q.push_back(txt[i]);
        end
        6, 7: begin
          str_q.push_back(ChPct);
          str_q.push_back(hex_char());
          str_q.push_back(hex_char());
        end
        8: begin
          str_q.push_back(ChPct);
          if ($urandom_range(0, 1)) str_q.push_back(hex_char());
          if ($urandom_range(0, 2) == 0) str_q.push_back(ChPct);
          else if ($urandom_range(0, 3) != 0) str_q.push_back(non_hex());
        end
        default: str_q.push_back(odd[$urandom_range(0, odd.len() - 1)]);
      endcase
    end
  endtask

  // holds the request until taken; predicted bytes queued on acceptance when use_model is set
  task automatic send_byte(logic [7:0] c, logic last, logic use_model);
    in_valid_i <= 1'b1;
    in_char_i  <= c;
    in_last_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    decode_byte(c, last);
    if (use_model) begin
      foreach (new_bytes[i]) begin
        decoded_q.push_back('{new_bytes[i], last && (i == new_bytes.size() - 1)});
      end
    end
  endtask

  task automatic idle_gap();
    int unsigned r;
    int unsigned gap;
    r   = $urandom_range(0, 99);
    gap = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(6, 25);
    if (quiet || (sent >= 160 && sent < 200)) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // receiver pacing, with one long hold-off on request from the sender
  initial begin : sink_pacing
    int unsigned r;
    int unsigned len;
    int          holds_served;
    logic        stall;
    holds_served = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_req != holds_served) begin
        holds_served = hold_req;
        out_stall_i <= 1'b1;
        for (int n = 0; n < HoldCycles; n++) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (quiet) begin
          stall = 1'b0;
          len   = 1;
        end else if (r < 60) begin
          stall = 1'b0;
          len   = $urandom_range(1, 6);
        end else if (r < 92) begin
          stall = 1'b1;
          len   = $urandom_range(1, 3);
        end else begin
          stall = 1'b1;
          len   = $urandom_range(8, 30);
        end
        out_stall_i <= stall;
        repeat (len) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_out
    out_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: no byte expected, got char %02h last %0b",
                 $time, out_char_o, out_last_o);
      end else begin
        want = decoded_q.pop_front();
        if (out_char_o !== want.ch || out_last_o !== want.last) begin
          errors++;
          $display("%0t: expected char %02h last %0b, got char %02h last %0b",
                   $time, want.ch, want.last, out_char_o, out_last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    table_row_t r;
    bool_flags: begin end
    // zero and all-ones bytes, each alone as a whole string
    dir_rows.push_back(table_row(8'h00, 1'b1, 1'b1, 1'b1, 8'h00));
    dir_rows.push_back(table_row(8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF));
    // &#34; -> double quote
    dir_rows.push_back(table_row(ChAmp,  1'b0, 1'b1, 1'b0, 8'h00));
    dir_rows.push_back(table_row(ChHash, 1'b0, 1'b1, 1'b0, 8'h00));
    dir_rows.push_back(table_row(ChDig3, 1'b0, 1'b1, 1'b0, 8'h00));
    dir_rows.push_back(table_row(ChDig4, 1'b0, 1'b1, 1'b0, 8'h00));
    dir_rows.push_back(table_row(ChSemi, 1'b1, 1'b1, 1'b1, ChQuote));
    // mixed-case hex: %fF -> ff
    dir_rows.push_back(table_row(ChPct, 1'b0, 1'b1, 1'b0, 8'h00));
    dir_rows.push_back(table_row("f",   1'b0, 1'b1, 1'b0, 8'h00));
    dir_rows.push_back(table_row("F",   1'b1, 1'b1, 1'b1, 8'hFF));
    // decoded zero byte
    dir_rows.push_back(table_row(ChPct, 1'b0, 1'b1, 1'b0, 8'h00));
    dir_rows.push_back(table_row("0",   1'b0, 1'b1, 1'b0, 8'h00));
    dir_rows.push_back(table_row("0",   1'b1, 1'b1, 1'b1, 8'h00));
    // held digit, then &quot broken by '%' on the last byte: eight bytes out
    dir_rows.push_back(table_row(ChPct,  1'b0, 1'b0, 1'b0, 8'h00));
    dir_rows.push_back(table_row("A",    1'b0, 1'b0, 1'b0, 8'h00));
    dir_rows.push_back(table_row(ChAmp,  1'b0, 1'b0, 1'b0, 8'h00));
    dir_rows.push_back(table_row(ChLowQ, 1'b0, 1'b0, 1'b0, 8'h00));
    dir_rows.push_back(table_row(ChLowU, 1'b0, 1'b0, 1'b0, 8'h00));
    dir_rows.push_back(table_row(ChLowO, 1'b0, 1'b0, 1'b0, 8'h00));
    dir_rows.push_back(table_row(ChLowT, 1'b0, 1'b0, 1'b0, 8'h00));
    dir_rows.push_back(table_row(ChPct,  1'b1, 1'b0, 1'b0, 8'h00));
    // &amp; -> ampersand
    dir_rows.push_back(table_row(ChAmp,  1'b0, 1'b1, 1'b0, 8'h00));
    dir_rows.push_back(table_row(ChLowA, 1'b0, 1'b1, 1'b0, 8'h00));
    dir_rows.push_back(table_row(ChLowM, 1'b0, 1'b1, 1'b0, 8'h00));
    dir_rows.push_back(table_row(ChLowP, 1'b0, 1'b1, 1'b0, 8'h00));
    dir_rows.push_back(table_row(ChSemi, 1'b1, 1'b1, 1'b1, ChAmp));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_byte(r.ch, r.last, !r.typed);
      if (r.typed && r.one) decoded_q.push_back('{r.want, r.last});
      idle_gap();
    end

    while (sent < ItemTarget) begin
      build_string();
      foreach (str_q[i]) begin
        quiet = (sent >= 80 && sent < 120);
        if (sent >= 160 && hold_req == 0) hold_req = 1;  // receiver holds off, block fills
        send_byte(str_q[i], i == str_q.size() - 1, 1'b1);
        if (sent >= 240 && sent < 241) begin
          // sender pauses until every decoded byte is out
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (decoded_q.size() != 0);
        end else begin
          idle_gap();
        end
      end
    end
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (decoded_q.size() != 0);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/epd_pkg.sv
design/entity_percent_decoder.sv
tb/sv/entity_percent_decoder_tb.sv
